// ===== rtl/isrt_pkg.sv =====
// Shared types for the interval sort and merge block.
package isrt_pkg;

   typedef struct packed {
      logic signed [31:0] ival_start;
      logic signed [31:0] ival_end;
      logic               store;
      logic               set_last;
      logic               dropped;
   } queue_entry_type;

   localparam int unsigned QueueDepth = 2;

endpackage

// ===== rtl/isrt_front.sv =====
// Front end: accepts intervals, classifies store or drop, queues them.
module isrt_front import isrt_pkg::*; #(
   parameter int unsigned MAX_INTERVALS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_interval_start,
   input  logic signed [31:0] req_interval_end,
   input  logic               req_set_last,
   output logic               q_valid,
   output queue_entry_type    q_entry,
   input  logic               q_pop
);

   localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

   logic [CW-1:0]   count_ff, count_in;
   logic            ovf_ff, ovf_in;
   queue_entry_type slot_ff [QueueDepth];
   logic            wptr_ff, rptr_ff;
   logic [1:0]      fill_ff;
   logic            accept, store;

   assign busy    = (fill_ff == 2'(QueueDepth));
   assign accept  = start & ~busy;
   assign store   = (count_ff < CW'(MAX_INTERVALS));
   assign q_valid = (fill_ff != 2'd0);
   assign q_entry = slot_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (req_set_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_ff + CW'(store);
            ovf_in   = ovf_ff | ~store;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         fill_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (accept) wptr_ff <= ~wptr_ff;
         if (q_pop && q_valid) rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + 2'(accept) - 2'(q_pop && q_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wptr_ff].ival_start <= req_interval_start;
         slot_ff[wptr_ff].ival_end   <= req_interval_end;
         slot_ff[wptr_ff].store      <= store;
         slot_ff[wptr_ff].set_last   <= req_set_last;
         slot_ff[wptr_ff].dropped    <= ovf_ff | ~store;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_INTERVALS)) else $error("count over capacity");
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(QueueDepth)) else $error("queue overfilled");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_set_last |=> count_ff == '0 && !ovf_ff)
      else $error("set not cleared");

endmodule

// ===== rtl/isrt_back.sv =====
// Back end: insertion into a sorted store, then a merge pass over it.
module isrt_back import isrt_pkg::*; #(
   parameter int unsigned MAX_INTERVALS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  queue_entry_type    q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_merged_start,
   output logic signed [31:0] rsp_merged_end,
   output logic               rsp_run_last,
   output logic               rsp_dropped_any
);

   localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
   localparam int unsigned IW = $clog2(MAX_INTERVALS);

   typedef enum logic [2:0] {
      S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_MRG_RD, S_MRG_PROC, S_FIN
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      n_ff, j_ff, i_ff;
   logic signed [31:0] key_s_ff, key_e_ff, lo_ff, hi_ff;
   logic               last_ff, drop_ff;
   logic [63:0]        mem [MAX_INTERVALS];
   logic [63:0]        rdata_ff;
   logic [IW-1:0]      raddr, waddr;
   logic [63:0]        wdata;
   logic               we;
   logic signed [31:0] rd_s, rd_e;
   logic               key_before;
   logic [CW-1:0]      jm1;

   assign rd_s = rdata_ff[63:32];
   assign rd_e = rdata_ff[31:0];
   assign jm1  = j_ff - CW'(1);
   assign key_before = (key_s_ff < rd_s) || (key_s_ff == rd_s && key_e_ff < rd_e);
   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      raddr = (state_ff == S_MRG_RD) ? i_ff[IW-1:0] : jm1[IW-1:0];
      we    = 1'b0;
      waddr = j_ff[IW-1:0];
      wdata = {key_s_ff, key_e_ff};
      case (state_ff)
         S_IDLE: begin
            if (q_pop && q_entry.store && n_ff == '0) begin
               we    = 1'b1;
               waddr = '0;
               wdata = {q_entry.ival_start, q_entry.ival_end};
            end
         end
         S_INS_CMP: begin
            we = 1'b1;
            if (key_before) wdata = rdata_ff;
         end
         S_INS_PUT: begin
            we    = 1'b1;
            waddr = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         n_ff      <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  key_s_ff <= q_entry.ival_start;
                  key_e_ff <= q_entry.ival_end;
                  last_ff  <= q_entry.set_last;
                  drop_ff  <= q_entry.dropped;
                  j_ff     <= n_ff;
                  i_ff     <= '0;
                  if (q_entry.store && n_ff != '0) begin
                     state_ff <= S_INS_RD;
                  end else begin
                     if (q_entry.store) n_ff <= CW'(1);
                     state_ff <= q_entry.set_last ? S_MRG_RD : S_IDLE;
                  end
               end
            end
            S_INS_RD: begin
               state_ff <= S_INS_CMP;
            end
            S_INS_CMP: begin
               if (key_before) begin
                  j_ff     <= jm1;
                  state_ff <= (jm1 == '0) ? S_INS_PUT : S_INS_RD;
               end else begin
                  n_ff     <= n_ff + CW'(1);
                  state_ff <= last_ff ? S_MRG_RD : S_IDLE;
               end
            end
            S_INS_PUT: begin
               n_ff     <= n_ff + CW'(1);
               state_ff <= last_ff ? S_MRG_RD : S_IDLE;
            end
            S_MRG_RD: begin
               state_ff <= S_MRG_PROC;
            end
            S_MRG_PROC: begin
               if (i_ff == '0) begin
                  lo_ff <= rd_s;
                  hi_ff <= rd_e;
               end else if (!(rd_s >= lo_ff && rd_e <= hi_ff) && rd_e > hi_ff) begin
                  if (rd_s >= lo_ff && rd_s <= hi_ff) begin
                     hi_ff <= rd_e;
                  end else begin
                     rsp_valid        <= 1'b1;
                     rsp_merged_start <= lo_ff;
                     rsp_merged_end   <= hi_ff;
                     rsp_run_last     <= 1'b0;
                     rsp_dropped_any  <= drop_ff;
                     lo_ff            <= rd_s;
                     hi_ff            <= rd_e;
                  end
               end
               i_ff     <= i_ff + CW'(1);
               state_ff <= (i_ff + CW'(1) == n_ff) ? S_FIN : S_MRG_RD;
            end
            S_FIN: begin
               rsp_valid        <= 1'b1;
               rsp_merged_start <= lo_ff;
               rsp_merged_end   <= hi_ff;
               rsp_run_last     <= 1'b1;
               rsp_dropped_any  <= drop_ff;
               n_ff             <= '0;
               state_ff         <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_n_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(MAX_INTERVALS)) else $error("store count over capacity");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> state_ff == S_IDLE && n_ff == '0)
      else $error("set not closed after final result");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE) else $error("pop while working");

endmodule

// ===== rtl/interval_sort_merge.sv =====
// Top level: sorts a set of signed intervals and emits the merged runs.
// Loading: one interval per cycle while the two-entry queue has room; each
// stored interval needs a read and a compare state per entry examined and a put
// state if it goes first. Merge: a read and a process state per stored interval
// on the single memory read port, then a final result. Results cannot be stalled.
// Reset: synchronous, empties the queue, counts and control; memory is not cleared.
module interval_sort_merge import isrt_pkg::*; #(
   parameter int unsigned MAX_INTERVALS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_interval_start,
   input  logic signed [31:0] req_interval_end,
   input  logic               req_set_last,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_merged_start,
   output logic signed [31:0] rsp_merged_end,
   output logic               rsp_run_last,
   output logic               rsp_dropped_any
);

   logic            q_valid, q_pop;
   queue_entry_type q_entry;

   isrt_front #(.MAX_INTERVALS(MAX_INTERVALS)) u_front (
      .clock, .reset, .start, .busy,
      .req_interval_start, .req_interval_end, .req_set_last,
      .q_valid, .q_entry, .q_pop
   );

   isrt_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
      .clock, .reset, .q_valid, .q_entry, .q_pop,
      .rsp_valid, .rsp_merged_start, .rsp_merged_end,
      .rsp_run_last, .rsp_dropped_any
   );

endmodule
